/* sv/are_pkg.sv */
// Package for the adaptive range encoder: payload structs, state enum, constants.
// Used by every module in sv/.
package are_pkg;

	localparam int unsigned NUM_CONTEXTS_DEF = 5;
	localparam int unsigned NUM_SYMBOLS_DEF  = 256;
	localparam logic [31:0] TOP_LIMIT    = 32'h0100_0000;
	localparam logic [31:0] BOTTOM_LIMIT = 32'h0001_0000;
	localparam logic [31:0] RANGE_INIT   = 32'hffff_ffff;

	localparam logic CMD_ENCODE = 1'b0;
	localparam logic CMD_FLUSH  = 1'b1;

	typedef struct packed {
		logic       cmd;
		logic [7:0] symbol;
		logic [2:0] context_req;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_NORM,
		ST_EMIT,
		ST_CUM,
		ST_DIV,
		ST_MUL_LOW,
		ST_MUL_RNG,
		ST_UPDATE,
		ST_RESCALE,
		ST_FLUSH
	} state_t;

endpackage

/* sv/adaptive_range_encoder_core.sv */
// Adaptive carry-less range encoder, top level. Depends on are_pkg, are_ctrl, are_freq_mem.
// An encode normalizes (emitting bytes), walks the counts below its symbol and divides;
// the cumulative walk reads one count per cycle and the divide follows it.
// A total that reaches 0xffff adds a rescale pass. A flush emits four bytes.
// Output stalls hold the emit and flush steps; one item is in flight at a time.
// After reset every count is set to 1, over all NUM_CONTEXTS*NUM_SYMBOLS entries (1280).
module adaptive_range_encoder_core
	import are_pkg::*;
#(
	parameter int unsigned NUM_CONTEXTS = NUM_CONTEXTS_DEF,
	parameter int unsigned NUM_SYMBOLS  = NUM_SYMBOLS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  in_data,
	input  logic      in_valid,
	output logic      in_ready,
	output out_item_t out_data,
	output logic      out_valid,
	input  logic      out_ready
);

	localparam int unsigned DEPTH = NUM_CONTEXTS * NUM_SYMBOLS;
	localparam int unsigned AW    = $clog2(DEPTH);

	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [15:0]   mem_wdata, mem_rdata;

	are_ctrl #(
		.NUM_CONTEXTS (NUM_CONTEXTS),
		.NUM_SYMBOLS  (NUM_SYMBOLS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	are_freq_mem #(
		.DEPTH (DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

/* sv/are_div.sv */
// Restoring divider, one quotient bit per cycle, then a done pulse with the quotient.
// Depends on are_pkg for house conventions only.
module are_div
	import are_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [15:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);

	logic [31:0] quot_q;
	logic [16:0] rem_q;
	logic [15:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] trial;
	logic [17:0] diff;

	assign trial = {rem_q[15:0], quot_q[31]};
	assign diff  = {1'b0, trial} - {2'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			// The last quotient bit lands at the edge that ends the busy phase.
			done_q <= busy_q && (cnt_q == 6'd1);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			if (!diff[17]) begin
				rem_q  <= diff[16:0];
				quot_q <= {quot_q[30:0], 1'b1};
			end else begin
				rem_q  <= trial;
				quot_q <= {quot_q[30:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

`ifndef SYNTH
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider restarted while busy");
	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy_q) else $error("divider still busy at done");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q != 6'd0)) else $error("divider count underflow");
`endif

endmodule

/* sv/are_freq_mem.sv */
// Frequency count memory: one write and one registered read port.
// Depends on are_pkg for house conventions only.
module are_freq_mem
	import are_pkg::*;
#(
	parameter int unsigned DEPTH = NUM_CONTEXTS_DEF * NUM_SYMBOLS_DEF,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [15:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [15:0]   rdata
);

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* sv/are_ctrl.sv */
// Sequencer and datapath of the range encoder: normalize, cumulative walk,
// divide, two multiplies, model update, rescale and flush. Uses are_pkg, are_div.
module are_ctrl
	import are_pkg::*;
#(
	parameter int unsigned NUM_CONTEXTS = NUM_CONTEXTS_DEF,
	parameter int unsigned NUM_SYMBOLS  = NUM_SYMBOLS_DEF,
	parameter int unsigned DEPTH        = NUM_CONTEXTS * NUM_SYMBOLS,
	parameter int unsigned AW           = $clog2(DEPTH),
	parameter int unsigned SW           = $clog2(NUM_SYMBOLS + 1),
	parameter int unsigned CW           = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  in_item_t      in_data,
	input  logic          in_valid,
	output logic          in_ready,
	output out_item_t     out_data,
	output logic          out_valid,
	input  logic          out_ready,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output logic [15:0]   mem_wdata,
	output logic [AW-1:0] mem_raddr,
	input  logic [15:0]   mem_rdata
);

	state_t state_q, state_d;

	logic [31:0] low_q, range_q, step_q;
	logic [15:0] total_q [NUM_CONTEXTS];
	logic [15:0] fsym_q, sum_q;
	logic [31:0] cum_q;
	logic [CW-1:0] ctx_q;
	logic [SW-1:0] sym_q;
	logic [SW-1:0] idx_q;
	logic          rd_pend_q;
	logic [AW-1:0] clr_q;
	logic [2:0]    nout_q;
	logic          flush_q;
	logic          out_valid_q;
	out_item_t     out_q;

	logic [AW-1:0] base;
	logic [31:0]   sum_lr, shl_low, shl_rng, fix_rng, sum_nx;
	logic          need_norm, need_nx, in_ok, div_start, div_done, out_load;
	logic [31:0]   quotient;
	logic [15:0]   tot_cur;
	logic [63:0]   prod;
	logic [15:0]   halved;
	logic          walk_end;

	assign base      = AW'(ctx_q * NUM_SYMBOLS);
	assign tot_cur   = total_q[ctx_q];
	assign sum_lr    = low_q + range_q;
	assign need_norm = ((low_q ^ sum_lr) < TOP_LIMIT) || (range_q < BOTTOM_LIMIT);
	assign shl_low   = {low_q[23:0], 8'h00};
	assign shl_rng   = {range_q[23:0], 8'h00};
	assign fix_rng   = ((shl_rng + shl_low) < shl_low) ? ~shl_low : shl_rng;
	// Whether normalization goes on after the byte being emitted now.
	assign sum_nx    = shl_low + fix_rng;
	assign need_nx   = ((shl_low ^ sum_nx) < TOP_LIMIT) || (fix_rng < BOTTOM_LIMIT);
	assign out_load  = ((state_q == ST_FLUSH) || (state_q == ST_EMIT)) &&
		(!out_valid_q || out_ready);
	assign in_ok     = (in_data.cmd == CMD_FLUSH) ||
		((32'(in_data.context_req) < NUM_CONTEXTS) && (32'(in_data.symbol) < NUM_SYMBOLS));
	assign halved    = {1'b0, mem_rdata[15:1]} | 16'd1;
	assign walk_end  = (idx_q == SW'(NUM_SYMBOLS));

	// One shared 32x32 multiplier, operands chosen by the state.
	always_comb begin
		if (state_q == ST_MUL_LOW) begin
			prod = cum_q * step_q;
		end else begin
			prod = step_q * {16'd0, mem_rdata};
		end
	end

	assign div_start = (state_q == ST_CUM) && walk_end;

	are_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (range_q),
		.divisor  ((tot_cur == 16'd0) ? 16'd1 : tot_cur),
		.done     (div_done),
		.quotient (quotient)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:   if (clr_q == AW'(DEPTH - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (in_valid && in_ok) begin
					state_d = (in_data.cmd == CMD_FLUSH) ? ST_FLUSH : ST_NORM;
				end
			end
			ST_FLUSH:   if (!out_valid_q || out_ready) begin
				if (nout_q == 3'd3) state_d = ST_IDLE;
			end
			ST_NORM: begin
				if (nout_q != 3'd4 && need_norm) state_d = ST_EMIT;
				else state_d = ST_CUM;
			end
			ST_EMIT:    if (!out_valid_q || out_ready) state_d = ST_NORM;
			ST_CUM:     if (walk_end) state_d = ST_DIV;
			ST_DIV:     if (div_done) state_d = ST_MUL_LOW;
			ST_MUL_LOW: state_d = ST_MUL_RNG;
			ST_MUL_RNG: state_d = ST_UPDATE;
			ST_UPDATE:  state_d = (tot_cur == 16'hffff) ? ST_RESCALE : ST_IDLE;
			ST_RESCALE: if (walk_end && !rd_pend_q) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// Memory port control.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = base + AW'(idx_q);
		mem_wdata = halved;
		mem_raddr = base + AW'(idx_q);
		in_ready  = (state_q == ST_IDLE);
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = 16'd1;
			end
			ST_MUL_LOW: mem_raddr = base + AW'(sym_q);
			ST_UPDATE: begin
				mem_we    = 1'b1;
				mem_waddr = base + AW'(sym_q);
				mem_wdata = fsym_q + 16'd1;
			end
			ST_RESCALE: begin
				mem_we    = rd_pend_q;
				mem_waddr = base + AW'(idx_q - SW'(1));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			low_q       <= '0;
			range_q     <= RANGE_INIT;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			for (int c = 0; c < NUM_CONTEXTS; c++) total_q[c] <= 16'(NUM_SYMBOLS);
		end else begin
			state_q <= state_d;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: clr_q <= clr_q + AW'(1);
				ST_FLUSH: if (out_load) begin
					out_q.out_byte <= low_q[31:24];
					out_q.last     <= (nout_q == 3'd3);
					low_q          <= shl_low;
				end
				ST_EMIT: if (out_load) begin
					out_q.out_byte <= low_q[31:24];
					out_q.last     <= (nout_q == 3'd3) || !need_nx;
					low_q          <= shl_low;
					range_q        <= fix_rng;
				end
				ST_MUL_LOW: low_q <= low_q + prod[31:0];
				ST_MUL_RNG: range_q <= prod[31:0];
				ST_UPDATE: begin
					if (tot_cur != 16'hffff) total_q[ctx_q] <= tot_cur + 16'd1;
				end
				ST_RESCALE: begin
					if (rd_pend_q) total_q[ctx_q] <= sum_q + halved;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				ctx_q     <= CW'(in_data.context_req);
				sym_q     <= SW'(in_data.symbol);
				flush_q   <= in_data.cmd;
				nout_q    <= '0;
				idx_q     <= '0;
				cum_q     <= '0;
				rd_pend_q <= 1'b0;
			end
			ST_FLUSH: if (!out_valid_q || out_ready) nout_q <= nout_q + 3'd1;
			ST_EMIT:  if (!out_valid_q || out_ready) nout_q <= nout_q + 3'd1;
			ST_NORM: begin
				idx_q     <= '0;
				rd_pend_q <= 1'b0;
			end
			ST_CUM: begin
				// Read of count idx issued last cycle arrives now.
				if (rd_pend_q) cum_q <= cum_q + {16'd0, mem_rdata};
				rd_pend_q <= !walk_end && (idx_q < sym_q);
				if (!walk_end) idx_q <= (idx_q < sym_q) ? idx_q + SW'(1) : SW'(NUM_SYMBOLS);
			end
			ST_DIV: if (div_done) step_q <= quotient;
			ST_MUL_RNG: fsym_q <= mem_rdata;
			ST_UPDATE: begin
				idx_q     <= '0;
				sum_q     <= '0;
				rd_pend_q <= 1'b0;
			end
			ST_RESCALE: begin
				if (rd_pend_q) sum_q <= sum_q + halved;
				rd_pend_q <= !walk_end;
				if (!walk_end) idx_q <= idx_q + SW'(1);
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTH
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready) else $error("ready outside idle");
	a_norm_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (nout_q < 3'd4)) else $error("too many bytes");
	a_flush_unused: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |-> flush_q) else $error("flush state on encode");
`endif

endmodule
